[rtl/core/tds_pkg.sv]
// shared types and constants of the tridiagonal system solver
package tds_pkg;

  typedef struct packed {
    logic signed [31:0] sub_diag;
    logic signed [31:0] main_diag;
    logic signed [31:0] super_diag;
    logic signed [31:0] rhs;
    logic               last_row;
  } row_in_t;

  typedef struct packed {
    logic [5:0]         row_index;
    logic signed [31:0] solution;
    logic               final_result;
    logic [1:0]         status;
  } row_out_t;

  localparam logic [1:0] StatusOk   = 2'd0;
  localparam logic [1:0] StatusZero = 2'd1;
  localparam logic [1:0] StatusSat  = 2'd2;

  localparam logic signed [31:0] SatMax = 32'sh7fffffff;
  localparam logic signed [31:0] SatMin = 32'sh80000000;

  // saturate a 66 bit signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    begin
      if (v > 66'sd2147483647) r = SatMax;
      else if (v < -66'sd2147483648) r = SatMin;
      else r = v[31:0];
      return r;
    end
  endfunction

  function automatic logic clips(input logic signed [65:0] v);
    return (v > 66'sd2147483647) || (v < -66'sd2147483648);
  endfunction

endpackage

[rtl/core/tds_div.sv]
// iterative signed divider: floor-free truncating quotient of (num << frac) / den
module tds_div import tds_pkg::*; #(
  parameter int FracBits = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic               done_o,
  output logic signed [31:0] quot_o,
  output logic               sat_o
);
  localparam int NumW = 32 + FracBits;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] rem_num_q, rem_num_d;
  logic [32:0]     part_q, part_d;
  logic [31:0]     den_mag_q;
  logic [NumW-1:0] quo_q, quo_d;
  logic            neg_q, busy_q;
  logic [CntW-1:0] cnt_q;
  logic [33:0]     trial;
  logic [NumW:0]   sq;

  always_comb begin
    trial = {part_q, rem_num_q[NumW-1]} - {2'b00, den_mag_q};
    if (!trial[33]) begin
      part_d = trial[32:0];
      quo_d  = {quo_q[NumW-2:0], 1'b1};
    end else begin
      part_d = {part_q[31:0], rem_num_q[NumW-1]};
      quo_d  = {quo_q[NumW-2:0], 1'b0};
    end
    rem_num_d = {rem_num_q[NumW-2:0], 1'b0};
    sq = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(NumW);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_num_q <= NumW'(num_i[31] ? -{{FracBits{num_i[31]}}, num_i}
                                   : {{FracBits{1'b0}}, num_i}) << FracBits;
      den_mag_q <= den_i[31] ? 32'(-den_i) : 32'(den_i);
      neg_q     <= num_i[31] ^ den_i[31];
      part_q    <= '0;
      quo_q     <= '0;
    end else if (busy_q && cnt_q != '0) begin
      rem_num_q <= rem_num_d;
      part_q    <= part_d;
      quo_q     <= quo_d;
    end
    if (busy_q && cnt_q == '0) begin
      sat_o  <= clips(66'(signed'(sq)));
      quot_o <= sat32(66'(signed'(sq)));
    end
  end
endmodule

[rtl/core/tridiagonal_system_solver.sv]
// top level of the tridiagonal system solver
// channel | dir | handshake          | beat
// row     | in  | row_valid_i/stall_o| row_in_t, one matrix row
// result  | out | res_valid_o/stall_i| row_out_t, one unknown
// a stored row takes two passes through the iterative divider
// a row with a zero pivot skips the divider
// back substitution steps through SBRd, SBMul and SBSub per unknown, then SORd and SOut give one result at a time
// reset clears counters and status; the memories need no clearing
// a stalled result holds the sequencer
module tridiagonal_system_solver import tds_pkg::*; #(
  parameter int MAX_ROWS  = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     row_valid_i,
  output logic     row_stall_o,
  input  row_in_t  row_i,
  output logic     res_valid_o,
  input  logic     res_stall_i,
  output row_out_t res_o
);
  localparam int AW = $clog2(MAX_ROWS);
  localparam int CW = $clog2(MAX_ROWS + 1);

  typedef enum logic [3:0] {
    SIdle, SRd, SMul, SPiv, SDivC, SDivR, SWr, SBRd, SBMul, SBSub, SORd, SOut
  } state_e;

  state_e state_q;
  logic signed [31:0] sup_mem [MAX_ROWS];
  logic signed [31:0] rhs_mem [MAX_ROWS];
  logic signed [31:0] sup_rd_q, rhs_rd_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic wr_en;
  logic signed [31:0] wr_sup, wr_rhs;

  row_in_t row_q;
  logic [CW-1:0] rows_q;
  logic [1:0] err_q;
  logic signed [63:0] p1_q, p2_q;
  logic signed [31:0] piv_q, num_q, nsup_q, x_q, x_d;
  logic top_row;
  logic [AW-1:0] j_q;
  logic div_start, div_done, div_sat;
  logic signed [31:0] div_num, div_q;
  logic signed [63:0] mul_a, mul_b;
  logic signed [65:0] dpiv, dnum, dx;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sup_mem[wr_addr] <= wr_sup;
      rhs_mem[wr_addr] <= wr_rhs;
    end
    sup_rd_q <= sup_mem[rd_addr];
    rhs_rd_q <= rhs_mem[rd_addr];
  end

  tds_div #(.FracBits(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .start_i(div_start && (piv_q != '0)), .num_i(div_num), .den_i(piv_q),
    .done_o(div_done), .quot_o(div_q), .sat_o(div_sat)
  );

  assign row_stall_o = (state_q != SIdle);
  assign div_num = (state_q == SDivC) ? row_q.super_diag : num_q;

  // products shifted arithmetically: floor division by 2^frac
  assign mul_a = (64'(sup_rd_q) * 64'(row_q.sub_diag)) >>> FRAC_BITS;
  assign mul_b = (64'(rhs_rd_q) * 64'(row_q.sub_diag)) >>> FRAC_BITS;
  assign dpiv = 66'(row_q.main_diag) - 66'(p1_q);
  assign dnum = 66'(row_q.rhs) - 66'(p2_q);
  assign dx   = 66'(rhs_rd_q) - 66'(p1_q);

  always_comb begin
    rd_addr = AW'(rows_q - 1'b1);
    if (state_q == SBRd || state_q == SBMul || state_q == SBSub || state_q == SORd ||
        state_q == SOut) rd_addr = j_q;
    top_row = (j_q == AW'(rows_q - 1'b1));
    x_d = top_row ? rhs_rd_q : sat32(dx);
    wr_en = (state_q == SWr) || (state_q == SBSub);
    // unknowns overwrite the rhs store, read out once the run status is final
    if (state_q == SBSub) begin
      wr_addr = j_q;
      wr_sup = sup_rd_q;
      wr_rhs = x_d;
    end else begin
      wr_addr = AW'(rows_q);
      wr_sup = (piv_q == 0 || row_q.last_row) ? '0 : nsup_q;
      wr_rhs = (piv_q == 0) ? '0 : div_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rows_q <= '0;
      err_q <= StatusOk;
      res_valid_o <= 1'b0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state_q)
        SIdle: if (row_valid_i) begin
          row_q <= row_i;
          if (rows_q == CW'(MAX_ROWS)) begin
            err_q <= StatusSat;
            if (row_i.last_row) begin
              j_q <= AW'(rows_q - 1'b1);
              state_q <= SBRd;
            end
          end else state_q <= SRd;
        end
        SRd: state_q <= SMul;
        SMul: begin
          p1_q <= mul_a;
          p2_q <= mul_b;
          state_q <= SPiv;
        end
        SPiv: begin
          if (rows_q == '0) begin
            piv_q <= row_q.main_diag;
            num_q <= row_q.rhs;
          end else begin
            piv_q <= sat32(dpiv);
            num_q <= sat32(dnum);
            if (clips(dpiv) || clips(dnum)) err_q <= StatusSat;
          end
          state_q <= SDivC;
          div_start <= 1'b1;
        end
        SDivC: begin
          if (piv_q == 0) begin
            div_start <= 1'b0;
            if (err_q == StatusOk) err_q <= StatusZero;
            state_q <= SWr;
          end else if (div_done) begin
            nsup_q <= div_q;
            if (div_sat && !row_q.last_row) err_q <= StatusSat;
            div_start <= 1'b1;
            state_q <= SDivR;
          end
        end
        SDivR: if (div_done) begin
          if (div_sat) err_q <= StatusSat;
          state_q <= SWr;
        end
        SWr: begin
          rows_q <= rows_q + 1'b1;
          if (row_q.last_row) begin
            j_q <= AW'(rows_q);
            state_q <= SBRd;
          end else state_q <= SIdle;
        end
        SBRd: state_q <= SBMul;
        SBMul: begin
          p1_q <= (64'(sup_rd_q) * 64'(x_q)) >>> FRAC_BITS;
          state_q <= SBSub;
        end
        SBSub: begin
          x_q <= x_d;
          if (!top_row && clips(dx)) err_q <= StatusSat;
          if (j_q == '0) begin
            j_q <= AW'(rows_q - 1'b1);
            state_q <= SORd;
          end else begin
            j_q <= j_q - 1'b1;
            state_q <= SBRd;
          end
        end
        SORd: state_q <= SOut;
        SOut: begin
          if (!res_valid_o) begin
            res_o.row_index <= 6'(j_q);
            res_o.solution <= rhs_rd_q;
            res_o.final_result <= (j_q == '0);
            res_o.status <= err_q;
            res_valid_o <= 1'b1;
          end else if (!res_stall_i) begin
            res_valid_o <= 1'b0;
            if (j_q == '0) begin
              rows_q <= '0;
              err_q <= StatusOk;
              state_q <= SIdle;
            end else begin
              j_q <= j_q - 1'b1;
              state_q <= SORd;
            end
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end
endmodule

[bench/tb.sv]
// self-checking bench for the tridiagonal system solver
`timescale 1ns / 100ps

module tb;
  import tds_pkg::*;

  localparam int MaxRows   = 64;
  localparam int FracBits  = 16;
  localparam int IdleLimit = 20000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     row_valid = 1'b0;
  logic     row_stall;
  row_in_t  row_beat = '0;
  logic     res_valid;
  logic     res_stall = 1'b0;
  row_out_t res_beat;

  row_in_t  pending_rows[$];
  row_out_t expected_unknowns[$];

  // predictor state
  logic signed [31:0] norm_super[MaxRows];
  logic signed [31:0] norm_rhs[MaxRows];
  int                 rows_held = 0;
  logic [1:0]         run_status = StatusOk;

  int  errors = 0;
  int  row_gap = 0;
  int  stall_len = 0;
  int  idle_cycles = 0;
  bit  quiet_phase = 0;

  always #2 clk_i = ~clk_i;

  tridiagonal_system_solver #(.MAX_ROWS(MaxRows), .FRAC_BITS(FracBits)) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_valid_i (row_valid),
    .row_stall_o (row_stall),
    .row_i       (row_beat),
    .res_valid_o (res_valid),
    .res_stall_i (res_stall),
    .res_o       (res_beat)
  );

  function automatic void raise_status(logic [1:0] code);
    if (code > run_status) run_status = code;
  endfunction

  function automatic logic signed [31:0] clip32(longint v);
    if (v > 64'sd2147483647) begin
      raise_status(StatusSat);
      return SatMax;
    end
    if (v < -64'sd2147483648) begin
      raise_status(StatusSat);
      return SatMin;
    end
    return v[31:0];
  endfunction

  // product rounded toward minus infinity
  function automatic longint fixed_mul(logic signed [31:0] x, logic signed [31:0] y);
    longint p;
    p = longint'(x) * longint'(y);
    return p >>> FracBits;
  endfunction

  function automatic logic signed [31:0] fixed_div(logic signed [31:0] num,
                                                   logic signed [31:0] den);
    longint n;
    n = longint'(num) <<< FracBits;
    return clip32(n / longint'(den));
  endfunction

  // forward elimination of one row, back substitution on the last one
  function automatic void eliminate_row(row_in_t r);
    logic signed [31:0] piv, num;
    logic signed [31:0] unknown[MaxRows];
    row_out_t           o;
    int                 n, j;
    if (rows_held >= MaxRows) begin
      raise_status(StatusSat);
      if (!r.last_row) return;
    end else begin
      j = rows_held;
      if (j == 0) begin
        piv = r.main_diag;
        num = r.rhs;
      end else begin
        piv = clip32(longint'(r.main_diag) - fixed_mul(norm_super[j-1], r.sub_diag));
        num = clip32(longint'(r.rhs) - fixed_mul(norm_rhs[j-1], r.sub_diag));
      end
      if (piv == 0) begin
        raise_status(StatusZero);
        norm_super[j] = 0;
        norm_rhs[j] = 0;
      end else begin
        norm_super[j] = r.last_row ? 32'sd0 : fixed_div(r.super_diag, piv);
        norm_rhs[j] = fixed_div(num, piv);
      end
      rows_held = j + 1;
      if (!r.last_row) return;
    end
    n = rows_held;
    unknown[n-1] = norm_rhs[n-1];
    for (j = n - 1; j > 0; j--)
      unknown[j-1] = clip32(longint'(norm_rhs[j-1]) - fixed_mul(norm_super[j-1], unknown[j]));
    for (j = n - 1; j >= 0; j--) begin
      o.row_index = j[5:0];
      o.solution = unknown[j];
      o.final_result = (j == 0);
      o.status = run_status;
      expected_unknowns.push_back(o);
    end
    rows_held = 0;
    run_status = StatusOk;
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if ($urandom_range(0, 31) == 0) quiet_phase = !quiet_phase;
    if (quiet_phase || p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid <= 1'b0;
    end else begin
      if (row_valid && !row_stall) eliminate_row(row_beat);
      if (!row_valid || !row_stall) begin
        if (row_gap > 0) begin
          row_gap--;
          row_valid <= 1'b0;
        end else if (pending_rows.size() > 0) begin
          row_beat <= pending_rows.pop_front();
          row_valid <= 1'b1;
          row_gap = pick_gap();
        end else begin
          row_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    row_out_t want;
    if (!rst_ni) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (expected_unknowns.size() == 0) begin
          $error("unexpected result beat row_index %0d", res_beat.row_index);
          errors++;
        end else begin
          want = expected_unknowns.pop_front();
          if (res_beat.row_index !== want.row_index) begin
            $error("row_index: expected %0d actual %0d", want.row_index, res_beat.row_index);
            errors++;
          end
          if (res_beat.solution !== want.solution) begin
            $error("solution: expected %0d actual %0d", want.solution, res_beat.solution);
            errors++;
          end
          if (res_beat.final_result !== want.final_result) begin
            $error("final_result: expected %0b actual %0b", want.final_result,
                   res_beat.final_result);
            errors++;
          end
          if (res_beat.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, res_beat.status);
            errors++;
          end
        end
      end
      if (stall_len > 0) begin
        stall_len--;
        res_stall <= 1'b1;
      end else begin
        stall_len = pick_gap();
        res_stall <= (stall_len > 0);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((row_valid && !row_stall) || (res_valid && !res_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tridiagonal_system_solver regression: fail");
      $finish;
    end
  end

  function automatic row_in_t make_row(bit last, bit wild);
    row_in_t r;
    if (wild) begin
      r.sub_diag = $urandom;
      r.main_diag = $urandom;
      r.super_diag = $urandom;
      r.rhs = $urandom;
    end else begin
      // diagonally dominant rows keep the solve well inside range
      r.sub_diag = $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
      r.super_diag = $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
      r.main_diag = $signed($urandom_range(32'h30000, 32'h80000));
      if ($urandom_range(0, 1)) r.main_diag = -r.main_diag;
      r.rhs = $signed($urandom_range(0, 32'h1000000)) - 32'sh800000;
      if ($urandom_range(0, 40) == 0) r.main_diag = 0;
    end
    r.last_row = last;
    return r;
  endfunction

  function automatic row_in_t fixed_row(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                        logic [31:0] d, bit last);
    row_in_t r;
    r.sub_diag = a;
    r.main_diag = b;
    r.super_diag = c;
    r.rhs = d;
    r.last_row = last;
    return r;
  endfunction

  function automatic void queue_system(int size, int wild_pct);
    for (int i = 0; i < size; i++)
      pending_rows.push_back(make_row(i == size - 1, $urandom_range(0, 99) < wild_pct));
  endfunction

  initial begin
    int queued;
    // single row, plain and with a zero pivot
    pending_rows.push_back(fixed_row(0, 32'h20000, 0, 32'h30000, 1));
    pending_rows.push_back(fixed_row(32'hffffffff, 0, 32'hffffffff, 32'h7fffffff, 1));
    // saturated quotient from a tiny pivot
    pending_rows.push_back(fixed_row(0, 32'h1, 32'h7fffffff, 32'h80000000, 1));
    // extremes of every field
    pending_rows.push_back(fixed_row(32'h80000000, 32'h7fffffff, 32'h80000000,
                                     32'h7fffffff, 0));
    pending_rows.push_back(fixed_row(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                                     32'h80000000, 0));
    pending_rows.push_back(fixed_row(32'hffffffff, 32'hffffffff, 32'h0, 32'h1, 1));
    // zero pivot in the middle of a system
    pending_rows.push_back(fixed_row(0, 32'h10000, 32'h10000, 32'h10000, 0));
    pending_rows.push_back(fixed_row(32'h10000, 32'h10000, 32'h10000, 32'h20000, 0));
    pending_rows.push_back(fixed_row(32'h10000, 32'h20000, 0, 32'h10000, 1));
    queue_system(4, 0);
    queue_system(3, 100);
    // row overflow: 66 rows, the last two dropped
    queue_system(66, 0);
    queued = 0;
    while (queued < 80) begin
      int size;
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      queue_system(size, 15);
      queued += size;
    end
    queue_system(MaxRows, 5);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_rows.size() == 0);
    @(posedge clk_i);
    while (row_valid) @(posedge clk_i);
    while (expected_unknowns.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0 && expected_unknowns.size() == 0) begin
      $display("tridiagonal_system_solver regression: pass");
    end else begin
      $display("tridiagonal_system_solver regression: fail");
    end
    $finish;
  end

endmodule

[tridiagonal_system_solver.f]
rtl/core/tds_pkg.sv
rtl/core/tds_div.sv
rtl/core/tridiagonal_system_solver.sv
bench/tb.sv
